/* sv/pwdd_pkg.sv */
// ----------------------------------------------------------------------------
// pwdd_pkg
// Shared types and constants of the pulse width drop detector.
// ----------------------------------------------------------------------------
package pwdd_pkg;

  localparam int unsigned VoltW  = 16;
  localparam int unsigned TickW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned RegW   = 16;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned RegIdxW = 3;

  // filter weight of the new sample, 0.1 in Q0.16; the old baseline keeps 65536 - this
  localparam logic [13:0] NewWeight = 14'd6554;

  // register reset values
  localparam logic [RegW-1:0] UpdatePeriodRst  = 16'd100;
  localparam logic [RegW-1:0] TrigMarginRst    = 16'd2048;
  localparam logic [RegW-1:0] MinWidthRst      = 16'd400;
  localparam logic [RegW-1:0] MaxWidthRst      = 16'd1100;
  localparam logic [RegW-1:0] DebounceTicksRst = 16'd1000;
  localparam logic [RegW-1:0] BaselineStartRst = 16'd22528;

  // register indexes (byte address / 4)
  localparam logic [RegIdxW-1:0] RegUpdatePeriod  = 3'd0;
  localparam logic [RegIdxW-1:0] RegTrigMargin    = 3'd1;
  localparam logic [RegIdxW-1:0] RegMinWidth      = 3'd2;
  localparam logic [RegIdxW-1:0] RegMaxWidth      = 3'd3;
  localparam logic [RegIdxW-1:0] RegDebounceTicks = 3'd4;
  localparam logic [RegIdxW-1:0] RegBaselineStart = 3'd5;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PULSE = 2'd1,
    MODE_HOLD  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [RegW-1:0] update_period;
    logic [RegW-1:0] trig_margin;
    logic [RegW-1:0] min_width;
    logic [RegW-1:0] max_width;
    logic [RegW-1:0] debounce_ticks;
    logic [RegW-1:0] baseline_start;
    logic            baseline_load;   // one-cycle strobe on a baseline_start write
  } cfg_t;

endpackage

/* sv/pwdd_in_if.sv */
// ----------------------------------------------------------------------------
// pwdd_in_if
// Sample channel: one voltage sample and its tick time stamp per beat.
// ----------------------------------------------------------------------------
interface pwdd_in_if
  import pwdd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VoltW-1:0] sample_voltage;
  logic [TickW-1:0] time_stamp;

  modport source (output valid, output sample_voltage, output time_stamp, input ready);
  modport sink   (input valid, input sample_voltage, input time_stamp, output ready);
endinterface

/* sv/pwdd_out_if.sv */
// ----------------------------------------------------------------------------
// pwdd_out_if
// Result channel: count, detect flag, mode and baseline per beat.
// ----------------------------------------------------------------------------
interface pwdd_out_if
  import pwdd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] object_count;
  logic              object_seen;
  logic [1:0]        detector_mode;
  logic [VoltW-1:0]  baseline_level;

  modport source (output valid, output object_count, output object_seen,
                  output detector_mode, output baseline_level, input ready);
  modport sink   (input valid, input object_count, input object_seen,
                  input detector_mode, input baseline_level, output ready);
endinterface

/* sv/pwdd_cfg.sv */
// ----------------------------------------------------------------------------
// pwdd_cfg
// APB register file holding the six 16-bit detector settings.
// ----------------------------------------------------------------------------
module pwdd_cfg
  import pwdd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [RegIdxW-1:0] idx;
  logic               wr_en;
  logic [RegW-1:0]    wval;
  logic [RegW-1:0]    rval;
  cfg_t               cfg_q;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign wval   = pwdata[RegW-1:0];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.update_period  <= UpdatePeriodRst;
      cfg_q.trig_margin    <= TrigMarginRst;
      cfg_q.min_width      <= MinWidthRst;
      cfg_q.max_width      <= MaxWidthRst;
      cfg_q.debounce_ticks <= DebounceTicksRst;
      cfg_q.baseline_start <= BaselineStartRst;
      cfg_q.baseline_load  <= 1'b0;
    end else begin
      cfg_q.baseline_load <= 1'b0;
      if (wr_en) begin
        unique case (idx)
          RegUpdatePeriod:  cfg_q.update_period  <= wval;
          RegTrigMargin:    cfg_q.trig_margin    <= wval;
          RegMinWidth:      cfg_q.min_width      <= wval;
          RegMaxWidth:      cfg_q.max_width      <= wval;
          RegDebounceTicks: cfg_q.debounce_ticks <= wval;
          RegBaselineStart: begin
            cfg_q.baseline_start <= wval;
            cfg_q.baseline_load  <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      RegUpdatePeriod:  rval = cfg_q.update_period;
      RegTrigMargin:    rval = cfg_q.trig_margin;
      RegMinWidth:      rval = cfg_q.min_width;
      RegMaxWidth:      rval = cfg_q.max_width;
      RegDebounceTicks: rval = cfg_q.debounce_ticks;
      RegBaselineStart: rval = cfg_q.baseline_start;
      default:          rval = '0;
    endcase
  end

  assign prdata = {{(DataW-RegW){1'b0}}, rval};
  assign cfg_o  = cfg_q;

endmodule

/* sv/pwdd_core.sv */
// ----------------------------------------------------------------------------
// pwdd_core
// Input register, one-pass baseline filter and pulse state machine, result
// register.
// ----------------------------------------------------------------------------
module pwdd_core
  import pwdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  pwdd_in_if.sink     in_if,
  pwdd_out_if.source  out_if
);

  // input register
  logic             in_v_q;
  logic [VoltW-1:0] smp_q;
  logic [TickW-1:0] ts_q;

  // detector state
  logic [VoltW-1:0]  base_q, base_d;
  logic [TickW-1:0]  last_upd_q;
  logic [TickW-1:0]  begin_q;
  logic [TickW-1:0]  finish_q;
  logic [CountW-1:0] count_q, count_d;
  mode_e             mode_q, mode_d;
  logic              seen_d;
  logic              upd;

  // result register
  logic              out_v_q;
  logic [CountW-1:0] res_count_q;
  logic              res_seen_q;
  mode_e             res_mode_q;
  logic [VoltW-1:0]  res_base_q;

  logic adv;
  logic in_take;

  assign adv        = in_v_q & (~out_v_q | out_if.ready);
  assign in_if.ready = ~in_v_q | adv;
  assign in_take    = in_if.valid & in_if.ready;

  // baseline filter: b*58982 + s*6554 == b*65536 + (s - b)*6554
  logic signed [VoltW:0]   diff;
  logic signed [30:0]      prod;
  logic signed [32:0]      acc;
  logic [VoltW-1:0]        base_upd;
  logic signed [VoltW+1:0] level;
  logic                    below;
  logic [TickW-1:0]        width;
  logic [TickW-1:0]        since_upd;
  logic [TickW-1:0]        since_fin;

  always_comb begin
    since_upd = ts_q - last_upd_q;
    upd       = since_upd >= {{(TickW-RegW){1'b0}}, cfg_i.update_period};
    diff      = $signed({1'b0, smp_q}) - $signed({1'b0, base_q});
    prod      = 31'(diff) * $signed({17'd0, NewWeight});
    acc       = $signed({1'b0, base_q, 16'd0}) + 33'(prod);
    base_upd  = acc[31:16];
    base_d    = upd ? base_upd : base_q;

    level = $signed({2'b00, base_d}) - $signed({2'b00, cfg_i.trig_margin});
    below = $signed({2'b00, smp_q}) < level;

    width     = ts_q - begin_q;
    since_fin = ts_q - finish_q;

    mode_d  = mode_q;
    count_d = count_q;
    seen_d  = 1'b0;
    unique case (mode_q)
      MODE_IDLE: begin
        if (below) mode_d = MODE_PULSE;
      end
      MODE_PULSE: begin
        if (width > {{(TickW-RegW){1'b0}}, cfg_i.max_width}) begin
          mode_d = MODE_IDLE;
        end else if (!below && width >= {{(TickW-RegW){1'b0}}, cfg_i.min_width}) begin
          count_d = count_q + 1'b1;
          seen_d  = 1'b1;
          mode_d  = MODE_HOLD;
        end
      end
      MODE_HOLD: begin
        if (since_fin >= {{(TickW-RegW){1'b0}}, cfg_i.debounce_ticks}) mode_d = MODE_IDLE;
      end
      default: mode_d = MODE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
      base_q     <= BaselineStartRst;
      last_upd_q <= '0;
      begin_q    <= '0;
      finish_q   <= '0;
      count_q    <= '0;
      mode_q     <= MODE_IDLE;
    end else begin
      if (in_if.ready) in_v_q <= in_if.valid;
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (out_if.ready) begin
        out_v_q <= 1'b0;
      end
      if (cfg_i.baseline_load) begin
        base_q <= cfg_i.baseline_start;
      end else if (adv) begin
        base_q <= base_d;
      end
      if (adv) begin
        if (upd) last_upd_q <= ts_q;
        if (mode_q == MODE_IDLE && mode_d == MODE_PULSE) begin_q <= ts_q;
        if (seen_d) finish_q <= ts_q;
        count_q <= count_d;
        mode_q  <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      smp_q <= in_if.sample_voltage;
      ts_q  <= in_if.time_stamp;
    end
    if (adv) begin
      res_count_q <= count_d;
      res_seen_q  <= seen_d;
      res_mode_q  <= mode_d;
      res_base_q  <= base_d;
    end
  end

  assign out_if.valid          = out_v_q;
  assign out_if.object_count   = res_count_q;
  assign out_if.object_seen    = res_seen_q;
  assign out_if.detector_mode  = res_mode_q;
  assign out_if.baseline_level = res_base_q;

endmodule

/* sv/pulse_width_drop_detector.sv */
// ----------------------------------------------------------------------------
// pulse_width_drop_detector
// Photodiode drop detector: tracks a filtered baseline and counts pulses
// whose width lies between a minimum and a maximum.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  (sink)   one beat = sample_voltage (Q4.12) + time_stamp (ticks).
//   out_if (source) one beat per input beat: object_count, object_seen,
//                   detector_mode (0 idle, 1 pulse, 2 hold), baseline_level.
//   APB port        six 16-bit registers at byte offsets 0x00..0x14; writing
//                   baseline_start also reloads the baseline. Write only while
//                   no beat is in flight.
// An input beat passes through the input register, then the filter multiply,
// threshold compare and state update run in one pass into the result
// register. Throughput is one beat per cycle while out_if.ready stays high;
// the loop through the baseline filter multiplier and the mode register
// sets the clock period.
// When out_if.ready is low the result holds, the input register takes one
// more beat only if empty, then in_if.ready drops until the result is taken.
// Reset clears the count, timers and mode and loads the APB registers and the
// baseline with their default values.
// ----------------------------------------------------------------------------
module pulse_width_drop_detector
  import pwdd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  pwdd_in_if.sink          in_if,
  pwdd_out_if.source       out_if,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  pwdd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pwdd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // a counted object always leaves the detector in the hold state
  a_seen_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.object_seen |-> out_if.detector_mode == MODE_HOLD)
    else $error("object_seen without hold mode");

  // with the result register empty the input side never stalls
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled with empty result register");

  // a baseline_start write lands in the register and raises the reload strobe
  a_bstart_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[AddrW-1:2] == RegBaselineStart
    |=> cfg.baseline_load && cfg.baseline_start == $past(pwdata[RegW-1:0]))
    else $error("baseline_start write lost");

endmodule
